>>> design/assert_macros.svh
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/u8stc_pkg.sv
package u8stc_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CAP_W        = 13;
  localparam int unsigned MAX_CAPACITY = 4096;
  localparam int unsigned MAX_RES      = 5;
  localparam int unsigned PEND_DEPTH   = 3;
  localparam int unsigned LEN_W        = 3;
  localparam int unsigned PCNT_W       = 2;
  localparam int unsigned RES_IDX_W    = 3;

  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPACITY);

  localparam logic [BYTE_W-1:0] MASK_1B   = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2B   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_2B   = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3B   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_3B   = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4B   = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_4B   = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_CONT = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PAT  = 8'h80;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              term;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   ent;
    logic [RES_IDX_W-1:0] cnt;
  } burst_t;

endpackage

>>> design/u8stc_if.sv
interface u8stc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8stc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic       out_last;

  modport source (output valid, output out_byte, output out_end, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_end, input out_last,
                  output ready);
endinterface

>>> design/utf8_sanitizing_truncating_copy.sv
// UTF-8 sanitizing, truncating copy of a byte string.
// in_ch carries one source byte per transaction (in_byte, in_last); out_ch
// carries the copied bytes of whole, well-formed characters, then one
// terminator (out_end = 1, out_byte = 0) on the byte marked in_last when capacity is nonzero.
// out_last flags the final result caused by one input byte.
// cfg_we/cfg_wdata set the destination capacity (terminator included).
// Each byte is decoded in the cycle it is taken; its 0 to 5 results land in
// a burst register and leave one per cycle while out_ch is ready, from the
// next cycle on, so the first result shows in the cycle after acceptance.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_ch does not stall; a byte that yields more holds in_ch.ready low
// until the single-entry burst register, draining one result per cycle, is at its last result.
// in_ch.ready stays high while out_ch stalls only if no results are waiting.
// Reset clears the character and count state, sets capacity to 64 and
// empties the burst register; no clearing pass is needed.
`include "assert_macros.svh"

module utf8_sanitizing_truncating_copy (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [u8stc_pkg::CAP_W-1:0] cfg_wdata,
  u8stc_in_if.sink                    in_ch,
  u8stc_out_if.source                 out_ch
);
  import u8stc_pkg::*;

  burst_t            burst;
  logic              free;
  logic              accept;
  logic              stopped;
  logic [PCNT_W-1:0] pcount;
  logic [LEN_W-1:0]  exp_len;

  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  u8stc_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .byte_in  (in_ch.in_byte),
    .last_in  (in_ch.in_last),
    .burst    (burst),
    .stopped  (stopped),
    .pcount   (pcount),
    .exp_len  (exp_len)
  );

  u8stc_burst u_burst (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .burst (burst),
    .free  (free),
    .out_ch(out_ch)
  );

  `ASSERT_IMPL(a_term_last, out_ch.valid && out_ch.out_end, out_ch.out_last, "terminator not last")
  `ASSERT_IMPL(a_term_zero, out_ch.valid && out_ch.out_end, out_ch.out_byte == '0, "terminator nonzero")
  `ASSERT_IMPL(a_pend_len, pcount != '0, exp_len > LEN_W'(pcount), "pending count overruns length")
  `ASSERT_NEXT(a_stop_clear, accept && in_ch.in_last, !stopped && pcount == '0, "state not cleared")

endmodule

>>> design/u8stc_track.sv
module u8stc_track (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [u8stc_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                       accept,
  input  logic [u8stc_pkg::BYTE_W-1:0] byte_in,
  input  logic                       last_in,
  output u8stc_pkg::burst_t          burst,
  output logic                       stopped,
  output logic [u8stc_pkg::PCNT_W-1:0] pcount,
  output logic [u8stc_pkg::LEN_W-1:0]  exp_len
);
  import u8stc_pkg::*;

  logic [CAP_W-1:0]  cap_r;
  logic [BYTE_W-1:0] pend_r   [PEND_DEPTH];
  logic [BYTE_W-1:0] pend_nxt [PEND_DEPTH];
  logic [LEN_W-1:0]  exp_r, exp_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [CAP_W-1:0]  wr_r, wr_nxt;
  logic              stop_r, stop_nxt;

  logic [CAP_W-1:0]  cap_eff;
  logic              fin_req;
  logic [LEN_W-1:0]  fin_len;
  logic              lead_req;
  logic [LEN_W-1:0]  lead_len;
  logic [LEN_W-1:0]  emit_len;
  logic              term;
  logic [CAP_W:0]    wr_sum;

  assign cap_eff = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;

  always_comb begin
    if ((byte_in & MASK_1B) == '0) begin
      lead_len = LEN_W'(1);
    end else if ((byte_in & MASK_2B) == LEAD_2B) begin
      lead_len = LEN_W'(2);
    end else if ((byte_in & MASK_3B) == LEAD_3B) begin
      lead_len = LEN_W'(3);
    end else if ((byte_in & MASK_4B) == LEAD_4B) begin
      lead_len = LEN_W'(4);
    end else begin
      lead_len = '0;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    exp_nxt  = exp_r;
    pcnt_nxt = pcnt_r;
    wr_nxt   = wr_r;
    stop_nxt = stop_r;
    fin_req  = 1'b0;
    fin_len  = '0;
    lead_req = 1'b0;
    emit_len = '0;
    term     = 1'b0;
    wr_sum   = '0;

    if (!stop_r) begin
      if (pcnt_r != '0 && exp_r > LEN_W'(1)) begin
        if ((byte_in & MASK_CONT) == CONT_PAT) begin
          if (LEN_W'(pcnt_r) + LEN_W'(1) >= exp_r) begin
            fin_req = 1'b1;
            fin_len = exp_r;
          end else if (pcnt_r < PCNT_W'(PEND_DEPTH)) begin
            pend_nxt[pcnt_r] = byte_in;
            pcnt_nxt         = pcnt_r + PCNT_W'(1);
          end else begin
            pcnt_nxt = '0;
            exp_nxt  = '0;
          end
        end else begin
          lead_req = 1'b1;
        end
      end else begin
        lead_req = 1'b1;
      end
    end

    if (lead_req) begin
      pcnt_nxt = '0;
      exp_nxt  = '0;
      if (byte_in == '0) begin
        stop_nxt = 1'b1;
      end else if (lead_len == LEN_W'(1)) begin
        fin_req = 1'b1;
        fin_len = lead_len;
      end else if (lead_len != '0) begin
        pend_nxt[0] = byte_in;
        pcnt_nxt    = PCNT_W'(1);
        exp_nxt     = lead_len;
      end
    end

    if (fin_req) begin
      wr_sum   = {1'b0, wr_r} + (CAP_W+1)'(fin_len);
      pcnt_nxt = '0;
      exp_nxt  = '0;
      if (wr_sum >= {1'b0, cap_eff}) begin
        stop_nxt = 1'b1;
      end else begin
        emit_len = fin_len;
        wr_nxt   = wr_sum[CAP_W-1:0];
      end
    end

    if (last_in) begin
      term     = (cap_eff != '0);
      pcnt_nxt = '0;
      exp_nxt  = '0;
      wr_nxt   = '0;
      stop_nxt = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (i < PEND_DEPTH) begin
        burst.ent[i].data = (LEN_W'(i) + LEN_W'(1) == emit_len) ? byte_in : pend_r[i];
      end else begin
        burst.ent[i].data = byte_in;
      end
      burst.ent[i].term = 1'b0;
      if (term && LEN_W'(i) == emit_len) begin
        burst.ent[i].data = '0;
        burst.ent[i].term = 1'b1;
      end
    end
    burst.cnt = RES_IDX_W'(emit_len) + RES_IDX_W'(term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_W'(64);
      exp_r  <= '0;
      pcnt_r <= '0;
      wr_r   <= '0;
      stop_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        exp_r  <= exp_nxt;
        pcnt_r <= pcnt_nxt;
        wr_r   <= wr_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

  assign stopped = stop_r;
  assign pcount  = pcnt_r;
  assign exp_len = exp_r;

endmodule

>>> design/u8stc_burst.sv
module u8stc_burst (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  u8stc_pkg::burst_t burst,
  output logic              free,
  u8stc_out_if.source       out_ch
);
  import u8stc_pkg::*;

  res_t [MAX_RES-1:0]   ent_r;
  logic [RES_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 valid;
  logic                 at_last;
  logic                 take;
  res_t                 cur;

  assign valid   = idx_r < cnt_r;
  assign at_last = (idx_r + RES_IDX_W'(1)) == cnt_r;
  assign take    = valid && out_ch.ready;
  assign free    = !valid || (take && at_last);

  always_comb begin
    cur = '0;
    if (valid) begin
      cur = ent_r[idx_r];
    end
  end

  assign out_ch.valid    = valid;
  assign out_ch.out_byte = cur.data;
  assign out_ch.out_end  = cur.term;
  assign out_ch.out_last = valid && at_last;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load && burst.cnt != '0) begin
      cnt_nxt = burst.cnt;
      idx_nxt = '0;
    end else if (take && at_last) begin
      cnt_nxt = '0;
      idx_nxt = '0;
    end else if (take) begin
      idx_nxt = idx_r + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst.cnt != '0) begin
      ent_r <= burst.ent;
    end
  end

endmodule
